### src/gddn_pkg.sv
package gddn_pkg;

    // Highest accepted year
    localparam int unsigned MAX_YEAR = 9999;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned DN_W    = 22;
    localparam int unsigned WD_W    = 3;
    // Unwrapped day count, wide enough for any 14-bit year
    localparam int unsigned CNT_W   = 23;
    // Octal digits of the day count, for the mod 7 reduction
    localparam int unsigned CNT_DIGITS = (CNT_W + 2) / 3;
    // floor(p / 100) for p < 2^14, as (p * 5243) >> 19
    localparam int unsigned Q100_W  = 8;
    localparam int unsigned PROD_W  = 27;
    localparam logic [PROD_W-1:0] RECIP_100 = 27'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned CORR_W  = 12;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // After year split
    typedef struct packed {
        logic               range_ok;
        logic [YEAR_W-1:0]  p;
        logic [Q100_W-1:0]  q100;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } split_t;

    // After calendar check; all zero for an invalid date
    typedef struct packed {
        logic              date_ok;
        logic              leap;
        logic [DOY_W-1:0]  doy;
        logic [CNT_W-1:0]  p365;
        logic [CORR_W-1:0] corr;
    } cal_t;

    typedef struct packed {
        logic             date_ok;
        logic             leap;
        logic [DOY_W-1:0] doy;
        logic [CNT_W-1:0] count;
    } cnt_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### src/gddn_decode.sv
// Stage 1: year split (p = year-1, p/100 by reciprocal)
// Stage 2: leap test, month/day check, day of year, year terms
module gddn_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gddn_pkg::date_t   in_date,
    output logic              out_valid,
    input  logic              out_ready,
    output gddn_pkg::cal_t    out_cal
);

    logic             s1_valid_reg;
    gddn_pkg::split_t s1_reg;
    gddn_pkg::split_t s1_next;
    logic             s1_ready;
    logic             s2_valid_reg;
    gddn_pkg::cal_t   s2_reg;
    gddn_pkg::cal_t   s2_next;
    logic             s2_ready;

    logic [gddn_pkg::PROD_W-1:0] prod;
    logic [gddn_pkg::YEAR_W-1:0] p1;

    always_comb begin
        p1   = in_date.year - 14'd1;
        prod = {{(gddn_pkg::PROD_W-gddn_pkg::YEAR_W){1'b0}}, p1} * gddn_pkg::RECIP_100;
        s1_next.p        = p1;
        s1_next.q100     = prod[gddn_pkg::RECIP_SHIFT +: gddn_pkg::Q100_W];
        s1_next.range_ok = (in_date.year != 14'd0)
                        && (in_date.year <= gddn_pkg::YEAR_W'(gddn_pkg::MAX_YEAR))
                        && (in_date.month >= gddn_pkg::MONTH_JAN)
                        && (in_date.month <= gddn_pkg::MONTH_DEC);
        s1_next.month    = in_date.month;
        s1_next.day      = in_date.day;
    end

    logic [gddn_pkg::YEAR_W-1:0] cent_part;
    logic [gddn_pkg::YEAR_W-1:0] r100;
    logic                        leap;
    logic [gddn_pkg::DAY_W-1:0]  len;
    logic                        ok;

    always_comb begin
        cent_part = gddn_pkg::YEAR_W'(s1_reg.q100) * 14'd100;
        r100      = s1_reg.p - cent_part;
        // year%4==0 <=> p%4==3; year%100==0 <=> p%100==99; year%400 adds q100%4==3
        leap = (s1_reg.p[1:0] == 2'b11)
            && ((r100 != 14'd99) || (s1_reg.q100[1:0] == 2'b11));
        len  = gddn_pkg::month_len(s1_reg.month)
             + gddn_pkg::DAY_W'(leap && (s1_reg.month == gddn_pkg::MONTH_FEB));
        ok   = s1_reg.range_ok && (s1_reg.day != 5'd0) && (s1_reg.day <= len);

        s2_next = '0;
        if (ok) begin
            s2_next.date_ok = 1'b1;
            s2_next.leap    = leap;
            s2_next.doy     = gddn_pkg::days_before(s1_reg.month)
                            + gddn_pkg::DOY_W'(s1_reg.day)
                            + gddn_pkg::DOY_W'(leap && (s1_reg.month > gddn_pkg::MONTH_FEB));
            s2_next.p365    = gddn_pkg::CNT_W'(s1_reg.p) * 23'd365;
            // p/4 - p/100 + p/400
            s2_next.corr    = gddn_pkg::CORR_W'(s1_reg.p[gddn_pkg::YEAR_W-1:2])
                            - gddn_pkg::CORR_W'(s1_reg.q100)
                            + gddn_pkg::CORR_W'(s1_reg.q100[gddn_pkg::Q100_W-1:2]);
        end
    end

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_cal   = s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

endmodule

### src/gddn_count.sv
// Stage 3: day count = p*365 + leap corrections + day of year
module gddn_count (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  gddn_pkg::cal_t  in_cal,
    output logic            out_valid,
    input  logic            out_ready,
    output gddn_pkg::cnt_t  out_cnt
);

    logic           valid_reg;
    gddn_pkg::cnt_t cnt_reg;
    gddn_pkg::cnt_t cnt_next;

    always_comb begin
        cnt_next.date_ok = in_cal.date_ok;
        cnt_next.leap    = in_cal.leap;
        cnt_next.doy     = in_cal.doy;
        cnt_next.count   = in_cal.p365 + gddn_pkg::CNT_W'(in_cal.corr)
                         + gddn_pkg::CNT_W'(in_cal.doy);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cnt   = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### src/gddn_weekday.sv
// Stage 4: count mod 7 by octal digit sums (8 == 1 mod 7), output register
module gddn_weekday (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  gddn_pkg::cnt_t              in_cnt,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_date_ok,
    output logic                        out_leap,
    output logic [gddn_pkg::DOY_W-1:0]  out_doy,
    output logic [gddn_pkg::DN_W-1:0]   out_dn,
    output logic [gddn_pkg::WD_W-1:0]   out_wd
);

    logic [3*gddn_pkg::CNT_DIGITS-1:0] padded;
    logic [5:0]                        sum1;
    logic [3:0]                        sum2;
    logic [gddn_pkg::WD_W-1:0]         wd_next;

    always_comb begin
        padded = (3*gddn_pkg::CNT_DIGITS)'(in_cnt.count);
        sum1   = '0;
        for (int i = 0; i < gddn_pkg::CNT_DIGITS; i++) begin
            sum1 = sum1 + 6'(padded[3*i +: 3]);
        end
        sum2    = 4'(sum1[5:3]) + 4'(sum1[2:0]);
        wd_next = (sum2 >= 4'd7) ? 3'(sum2 - 4'd7) : sum2[2:0];
    end

    logic                       valid_reg;
    logic                       date_ok_reg;
    logic                       leap_reg;
    logic [gddn_pkg::DOY_W-1:0] doy_reg;
    logic [gddn_pkg::DN_W-1:0]  dn_reg;
    logic [gddn_pkg::WD_W-1:0]  wd_reg;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_date_ok = date_ok_reg;
    assign out_leap    = leap_reg;
    assign out_doy     = doy_reg;
    assign out_dn      = dn_reg;
    assign out_wd      = wd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            date_ok_reg <= in_cnt.date_ok;
            leap_reg    <= in_cnt.leap;
            doy_reg     <= in_cnt.doy;
            dn_reg      <= in_cnt.count[gddn_pkg::DN_W-1:0];
            wd_reg      <= wd_next;
        end
    end

endmodule

### src/gregorian_date_to_day_number_unit.sv
// Gregorian date to day number and weekday converter.
// Slave stream (s_*): one date per transfer; tdata carries year, month, day.
// Master stream (m_*): one result per date, in input order; tdata carries
//   valid flag, leap flag, day of year, day number (1 Jan of year 1 = 1) and
//   weekday (0 Sunday .. 6 Saturday). Invalid dates (year outside 1..9999,
//   bad month or day) give valid flag 0 and all other fields 0.
// Throughput: one transfer per cycle while m_tready is high, set by the
//   four register stages (year split, calendar check, day count sum,
//   weekday/output register).
// Each stage holds its item when the next is full and stalled, so a stall
// on m_tready fills empty stages first; s_tready drops only once all four
// stages hold items. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; m_tvalid is low
// afterwards and the block is ready at once.
module gregorian_date_to_day_number_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] year_value, [17:14] month_value, [22:18] day_value, [23] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] date_valid, [1] leap_year, [10:2] day_of_year,
    // [32:11] day_number, [35:33] week_day, [39:36] zero
    output logic [39:0] m_tdata
);

    gddn_pkg::date_t in_date;
    gddn_pkg::cal_t  cal;
    gddn_pkg::cnt_t  cnt;
    logic            cal_valid;
    logic            cal_ready;
    logic            cnt_valid;
    logic            cnt_ready;

    logic                       date_ok;
    logic                       leap;
    logic [gddn_pkg::DOY_W-1:0] doy;
    logic [gddn_pkg::DN_W-1:0]  dn;
    logic [gddn_pkg::WD_W-1:0]  wd;

    assign in_date.year  = s_tdata[13:0];
    assign in_date.month = s_tdata[17:14];
    assign in_date.day   = s_tdata[22:18];

    // stages 1 and 2
    gddn_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_date   (in_date),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_cal   (cal)
    );

    // stage 3
    gddn_count u_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cal_valid),
        .in_ready  (cal_ready),
        .in_cal    (cal),
        .out_valid (cnt_valid),
        .out_ready (cnt_ready),
        .out_cnt   (cnt)
    );

    // stage 4, output register
    gddn_weekday u_weekday (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cnt_valid),
        .in_ready    (cnt_ready),
        .in_cnt      (cnt),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_date_ok (date_ok),
        .out_leap    (leap),
        .out_doy     (doy),
        .out_dn      (dn),
        .out_wd      (wd)
    );

    assign m_tdata = {4'b0000, wd, dn, doy, leap, date_ok};

`ifndef SYNTHESIS
    // invalid date carries all-zero result fields
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[39:1] == 39'd0))
        else $error("invalid date with nonzero result fields");

    // weekday always reduced below 7
    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:33] != 3'd7))
        else $error("week_day out of range");

    // valid date has day of year in 1..366
    a_doy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> ((m_tdata[10:2] != 9'd0) && (m_tdata[10:2] <= 9'd366)))
        else $error("day_of_year out of range");

    // input backpressure only while a result is waiting
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low with output free");
`endif

endmodule
